// ===== hw/rtl/bpsk_pkg.sv =====
// shared types, constants and sine table builder for the bpsk modulator
package bpsk_pkg;

   // defaults for top-level parameters
   localparam int DEF_PHASE_BITS  = 16;
   localparam int DEF_SAMPLE_BITS = 8;

   // fixed geometry
   localparam int MAX_BAUD_LENGTH  = 1024;
   localparam int POS_BITS         = $clog2(MAX_BAUD_LENGTH);
   localparam int LEN_BITS         = 11;
   localparam int SINE_TABLE_DEPTH = 256;
   localparam int IDX_BITS         = $clog2(SINE_TABLE_DEPTH);
   localparam int STEP_BITS        = 16;
   localparam int AMP_BITS         = 7;
   localparam int WIN_BITS         = 9;

   // job queue depth, power of two
   localparam int QUEUE_DEPTH = 2;

   // register map
   localparam int CSR_ADDR_BITS = 4;
   typedef enum logic [1:0] {
      REG_CARRIER_STEP = 2'd0,
      REG_AMPLITUDE    = 2'd1,
      REG_BAUD_LENGTH  = 2'd2,
      REG_WINDOW_STEP  = 2'd3
   } reg_index_type;

   // register reset values
   localparam logic [STEP_BITS-1:0] RST_CARRIER_STEP = 16'd8192;
   localparam logic [AMP_BITS-1:0]  RST_AMPLITUDE    = 7'd63;
   localparam logic [LEN_BITS-1:0]  RST_BAUD_LENGTH  = 11'd256;
   localparam logic [STEP_BITS-1:0] RST_WINDOW_STEP  = 16'd256;

   // one sample's work as classified by the front end
   typedef struct packed {
      logic [IDX_BITS-1:0] carrier_idx;
      logic [IDX_BITS-1:0] window_idx;
      logic                negate;
      logic                held;
      logic                last;
   } job_type;

   // Q30 fixed-point constants for the table builder
   localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   // round(127 * sin(2 pi i / depth)) by a Taylor series in integer Q30 math
   function automatic logic signed [7:0] sine_entry(input int unsigned i);
      logic [63:0] m;
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] t;
      logic [63:0] sv;
      logic [63:0] q;
      logic        neg;
      m   = 64'(i) * 64'd4;
      neg = 1'b0;
      if (m >= 64'(2 * SINE_TABLE_DEPTH)) begin
         neg = 1'b1;
         m   = m - 64'(2 * SINE_TABLE_DEPTH);
      end
      if (m > 64'(SINE_TABLE_DEPTH)) begin
         m = 64'(2 * SINE_TABLE_DEPTH) - m;
      end
      x  = (m * HALF_PI_Q30 + 64'(SINE_TABLE_DEPTH / 2)) / 64'(SINE_TABLE_DEPTH);
      x2 = (x * x) >> 30;
      t  = Q30_ONE - x2 / 64'd110;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd72;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
      sv = (x * t) >> 30;
      q  = (sv * 64'd127 + (64'd1 << 29)) >> 30;
      if (q > 64'd127) begin
         q = 64'd127;
      end
      return neg ? -$signed(8'(q)) : $signed(8'(q));
   endfunction

endpackage

// ===== hw/rtl/bpsk_raised_cosine_modulator.sv =====
// top level of the bpsk raised-cosine modulator with its register block
//
//  channel  | direction | signals                              | carries
//  req      | in        | req_tvalid/tready/tdata[7:0]         | symbol_bit in bit 0
//  rsp      | out       | rsp_tvalid/tready/tdata, rsp_tlast   | sample, baud_end
//  csr      | in        | csr_psel/penable/pwrite/paddr/pwdata | register writes and reads
//
// each sample passes through the back-end sequencer states in order (pop,
// table lookup, amplitude multiply, window multiply into the output register)
// the front end takes one bit per cycle while the two-entry job queue has room
// synchronous active-high reset clears the modulator state and the registers
// a stalled rsp side holds the result and backs up the queue, then req_tready
module bpsk_raised_cosine_modulator import bpsk_pkg::*; #(
   parameter int PHASE_BITS  = DEF_PHASE_BITS,
   parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
   input  logic                     clock,
   input  logic                     reset,
   // stream in
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [7:0]               req_tdata,   // [0] symbol_bit, [7:1] zero
   // stream out
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [((SAMPLE_BITS+7)/8)*8-1:0] rsp_tdata, // sample, then zero fill
   output logic                     rsp_tlast,   // baud_end
   // register port
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [31:0]              csr_pwdata,
   output logic [31:0]              csr_prdata,
   output logic                     csr_pready
);

   localparam int TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8;

   logic [STEP_BITS-1:0] carrier_step_ff;
   logic [AMP_BITS-1:0]  amplitude_ff;
   logic [LEN_BITS-1:0]  baud_length_ff;
   logic [STEP_BITS-1:0] window_step_ff;

   reg_index_type          csr_index;
   logic                   csr_write;
   logic                   push;
   logic                   pop;
   logic                   q_full;
   logic                   q_empty;
   job_type                push_job;
   job_type                head;
   logic [SAMPLE_BITS-1:0] sample;

   // register block
   assign csr_pready = 1'b1;
   assign csr_index  = reg_index_type'(csr_paddr[3:2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         carrier_step_ff <= RST_CARRIER_STEP;
         amplitude_ff    <= RST_AMPLITUDE;
         baud_length_ff  <= RST_BAUD_LENGTH;
         window_step_ff  <= RST_WINDOW_STEP;
      end else if (csr_write) begin
         case (csr_index)
            REG_CARRIER_STEP: carrier_step_ff <= csr_pwdata[STEP_BITS-1:0];
            REG_AMPLITUDE:    amplitude_ff    <= csr_pwdata[AMP_BITS-1:0];
            REG_BAUD_LENGTH:  baud_length_ff  <= csr_pwdata[LEN_BITS-1:0];
            REG_WINDOW_STEP:  window_step_ff  <= csr_pwdata[STEP_BITS-1:0];
            default: ;
         endcase
      end
   end

   // register readback
   always_comb begin
      case (csr_index)
         REG_CARRIER_STEP: csr_prdata = 32'(carrier_step_ff);
         REG_AMPLITUDE:    csr_prdata = 32'(amplitude_ff);
         REG_BAUD_LENGTH:  csr_prdata = 32'(baud_length_ff);
         REG_WINDOW_STEP:  csr_prdata = 32'(window_step_ff);
         default:          csr_prdata = '0;
      endcase
   end

   // front end
   bpsk_front #(
      .PHASE_BITS(PHASE_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .symbol_bit  (req_tdata[0]),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .carrier_step(carrier_step_ff),
      .baud_length (baud_length_ff),
      .window_step (window_step_ff),
      .queue_full  (q_full),
      .push        (push),
      .push_job    (push_job)
   );

   // job queue
   bpsk_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .push_job(push_job),
      .pop     (pop),
      .head    (head),
      .full    (q_full),
      .empty   (q_empty)
   );

   // back end
   bpsk_back #(
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .amplitude  (amplitude_ff),
      .queue_empty(q_empty),
      .head       (head),
      .pop        (pop),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_sample (sample),
      .out_last   (rsp_tlast)
   );

   assign rsp_tdata = TDATA_W'(sample);

endmodule

// ===== hw/rtl/bpsk_front.sv =====
// front end: accepts symbol bits, tracks baud and carrier state, emits jobs
module bpsk_front import bpsk_pkg::*; #(
   parameter int PHASE_BITS = DEF_PHASE_BITS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 symbol_bit,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  logic [STEP_BITS-1:0] carrier_step,
   input  logic [LEN_BITS-1:0]  baud_length,
   input  logic [STEP_BITS-1:0] window_step,
   input  logic                 queue_full,
   output logic                 push,
   output job_type              push_job
);

   logic [PHASE_BITS-1:0] phase_ff, phase_in;
   logic [POS_BITS-1:0]   pos_ff, pos_in;
   logic                  pol_ff, pol_in;
   logic                  held_ff, held_in;

   logic [LEN_BITS-1:0]          len;
   logic [LEN_BITS-1:0]          half;
   logic [LEN_BITS-1:0]          pos_plus;
   logic                         last;
   logic [POS_BITS+STEP_BITS-1:0] wprod;
   logic [STEP_BITS-1:0]         wphase;

   assign in_ready = !queue_full;
   assign push     = in_valid && in_ready;

   // clamp baud length and find its half point
   assign len  = (baud_length > LEN_BITS'(MAX_BAUD_LENGTH)) ?
                 LEN_BITS'(MAX_BAUD_LENGTH) : baud_length;
   assign half = len >> 1;

   // window phase is the baud position times the window step plus a quarter turn, modulo 2^16
   assign wprod  = (POS_BITS+STEP_BITS)'(pos_ff) * (POS_BITS+STEP_BITS)'(window_step);
   assign wphase = wprod[STEP_BITS-1:0] + STEP_BITS'(16384);

   assign pos_plus = LEN_BITS'(pos_ff) + LEN_BITS'(1);
   assign last     = (pos_plus >= len);

   // latch bit at baud start, flip polarity at half point of a zero bit
   always_comb begin
      held_in = (pos_ff == '0) ? symbol_bit : held_ff;
      pol_in  = pol_ff ^ (!held_in && (LEN_BITS'(pos_ff) == half));
      phase_in = phase_ff + PHASE_BITS'(carrier_step);
      pos_in   = last ? '0 : pos_plus[POS_BITS-1:0];
   end

   // job for the back end
   always_comb begin
      push_job.carrier_idx = phase_ff[PHASE_BITS-1 -: IDX_BITS];
      push_job.window_idx  = wphase[STEP_BITS-1 -: IDX_BITS];
      push_job.negate      = pol_in;
      push_job.held        = held_in;
      push_job.last        = last;
   end

   // modulator state advances on each accepted transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
         pos_ff   <= '0;
         pol_ff   <= 1'b0;
         held_ff  <= 1'b1;
      end else if (push) begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         pol_ff   <= pol_in;
         held_ff  <= held_in;
      end
   end

endmodule

// ===== hw/rtl/bpsk_queue.sv =====
// small job queue between front and back end
module bpsk_queue import bpsk_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   input  logic    pop,
   output job_type head,
   output logic    full,
   output logic    empty
);

   localparam int PTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int COUNT_BITS = $clog2(QUEUE_DEPTH + 1);

   job_type               mem_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;

   assign full  = (count_ff == COUNT_BITS'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = mem_ff[rd_ptr_ff];

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + PTR_BITS'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + COUNT_BITS'(1);
      end else if (pop && !push) begin
         count_in = count_ff - COUNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // job storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

   // no overflow or underflow
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !full) else $error("job pushed into full queue");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty) else $error("job popped from empty queue");

endmodule

// ===== hw/rtl/bpsk_back.sv =====
// back end: sine lookup, window and amplitude scaling, output register
module bpsk_back import bpsk_pkg::*; #(
   parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [AMP_BITS-1:0]    amplitude,
   input  logic                   queue_empty,
   input  job_type                head,
   output logic                   pop,
   output logic                   out_valid,
   input  logic                   out_ready,
   output logic [SAMPLE_BITS-1:0] out_sample,
   output logic                   out_last
);

   localparam int PROD_W = SAMPLE_BITS + 16;
   localparam int CENTER = (1 << (SAMPLE_BITS - 1)) - 1;
   localparam logic signed [PROD_W-1:0] CENTER_TERM = PROD_W'(CENTER) << 15;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_LOOK = 4'b0010,
      ST_MUL  = 4'b0100,
      ST_FIN  = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   job_type                  job_ff;
   logic signed [7:0]        s_ff;
   logic [WIN_BITS-1:0]      w_ff;
   logic signed [15:0]       p1_ff;
   logic [SAMPLE_BITS-1:0]   sample_ff;
   logic                     last_ff;
   logic                     valid_ff, valid_in;

   logic signed [7:0]        sine_rom [SINE_TABLE_DEPTH];
   logic signed [7:0]        s_raw;
   logic signed [7:0]        w_raw;
   logic signed [9:0]        w_sum;
   logic signed [PROD_W-1:0] prod;
   logic                     load;

   // constant sine table
   for (genvar g = 0; g < SINE_TABLE_DEPTH; g++) begin : g_rom
      assign sine_rom[g] = sine_entry(g);
   end

   assign s_raw = sine_rom[job_ff.carrier_idx];
   assign w_raw = sine_rom[job_ff.window_idx];
   assign w_sum = 10'sd128 + 10'(w_raw);

   // final product plus center; never negative so the shift floors
   assign prod = PROD_W'(p1_ff) * PROD_W'($signed({1'b0, w_ff})) + CENTER_TERM;

   assign pop  = (state_ff == ST_IDLE) && !queue_empty;
   assign load = (state_ff == ST_FIN) && (!valid_ff || out_ready);

   // sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (!queue_empty) begin
               state_in = ST_LOOK;
            end
         end
         ST_LOOK: state_in = ST_MUL;
         ST_MUL:  state_in = ST_FIN;
         ST_FIN: begin
            if (load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // output valid: set on load, cleared once taken
   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (pop) begin
         job_ff <= head;
      end
      if (state_ff == ST_LOOK) begin
         s_ff <= job_ff.negate ? -s_raw : s_raw;
         w_ff <= job_ff.held ? WIN_BITS'(256) : w_sum[WIN_BITS-1:0];
      end
      if (state_ff == ST_MUL) begin
         p1_ff <= 16'(s_ff) * 16'($signed({1'b0, amplitude}));
      end
      if (load) begin
         sample_ff <= prod[15 +: SAMPLE_BITS];
         last_ff   <= job_ff.last;
      end
   end

   assign out_valid  = valid_ff;
   assign out_sample = sample_ff;
   assign out_last   = last_ff;

   // a held result is never overwritten, and the work steps run in order
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !out_ready) |-> !load) else $error("pending result overwritten");
   a_look_to_mul: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOOK) |=> (state_ff == ST_MUL)) else $error("lookup not followed by multiply");

endmodule
